// ===== design/dlws_pkg.sv =====
// Shared types and constants for the dense layer weighted sum block.
// Holds the word layouts of both channels, register indexes and mode codes.
// No dependencies.
package dlws_pkg;

    localparam int IDX_W    = 10;
    localparam int DATA_W   = 16;
    localparam int SUM_W    = 48;
    localparam int ROW_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INPUT_MODE   = 2'd2;

    // Input modes; any code above sign mode behaves as sign mode
    localparam logic [1:0] MODE_FIXED = 2'd0;
    localparam logic [1:0] MODE_BIT   = 2'd1;
    localparam logic [1:0] MODE_SIGN  = 2'd2;

    // Request types
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_WEIGHT = 1'b1;

    // Offset of the raw weight byte in bit and sign modes
    localparam logic signed [31:0] BYTE_OFFSET = 32'sd128;
    localparam int Q16_SHIFT = 16;

    typedef struct packed {
        logic                     req_type;
        logic [IDX_W-1:0]         element_index;
        logic signed [DATA_W-1:0] input_value;
        logic signed [DATA_W-1:0] weight;
        logic signed [SUM_W-1:0]  prior_result;
    } in_word_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] row_sum;
        logic [ROW_W-1:0]        row_index;
        logic                    last_row;
    } out_word_t;

endpackage

// ===== design/dense_layer_weighted_sum.sv =====
// Top level of the dense layer weighted sum block: input store, counters,
// one compute stage and the result register. Depends on dlws_pkg, dlws_ram
// and dlws_mac.
//
//  channel | direction | handshake          | word
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_valid / s_ready  | dlws_pkg::in_word_t
//  m_      | out       | m_valid / m_ready  | dlws_pkg::out_word_t
//  cfg_    | in        | cfg_wr_en          | cfg_addr, cfg_wdata (no reply)
//
// One word is accepted per cycle while s_ready is high. The accepting edge
// also reads the input store (registered RAM port); on advance the stage
// runs the multiply-accumulate and loads the result register, so a row's
// closing weight word raises m_valid as it leaves the stage. Reset clears
// the counters, accumulator and all valid flags; the store is not cleared.
// When the compute stage holds a word and the result register is full and
// not taken, the stage holds and s_ready drops; otherwise s_ready stays high.
module dense_layer_weighted_sum #(
    parameter int MAX_INPUTS  = 1024,
    parameter int MAX_OUTPUTS = 4096,
    parameter int ACC_WIDTH   = 48
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  dlws_pkg::in_word_t                   s_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output dlws_pkg::out_word_t                  m_word,
    input  logic                                 cfg_wr_en,
    input  logic [dlws_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [dlws_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import dlws_pkg::*;

    localparam int CW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int RW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
    localparam logic [16:0] MAX_IN_W  = 17'(MAX_INPUTS);
    localparam logic [16:0] MAX_OUT_W = 17'(MAX_OUTPUTS);
    localparam int WW = 66;
    localparam logic signed [WW-1:0] SUM_MAX = (WW'(1) <<< (SUM_W - 1)) - WW'(1);
    localparam logic signed [WW-1:0] SUM_MIN = -SUM_MAX - WW'(1);

    // Configuration registers
    logic [10:0] input_count_reg;
    logic [12:0] output_count_reg;
    logic [1:0]  input_mode_reg;

    // Counters and accumulator
    logic [CW-1:0]               col_reg, col_next;
    logic [RW-1:0]               row_reg, row_next;
    logic signed [ACC_WIDTH-1:0] acc_reg, acc_next;

    // Compute stage
    logic                    s1_valid_reg;
    logic                    s1_weight_reg;
    logic                    s1_first_reg;
    logic                    s1_end_reg;
    logic [RW-1:0]           s1_row_reg;
    logic                    s1_last_row_reg;
    logic signed [15:0]      s1_wt_reg;
    logic signed [47:0]      s1_prior_reg;

    // Result register
    logic                    m_valid_reg;
    out_word_t               m_word_reg;

    logic        advance;
    logic        accept;
    logic        is_weight;
    logic [16:0] n_in, n_out;
    logic [16:0] col_plus, row_plus;
    logic        row_end, layer_end;
    logic [16:0] load_idx;
    logic        load_we;
    logic [15:0] store_rd;
    logic        s1_emit;
    logic signed [WW-1:0] acc_w;
    logic signed [SUM_W-1:0] sum_sat;

    // The compute stage moves whenever it is empty or the result register
    // can take what it produces.
    assign advance   = !s1_valid_reg || !m_valid_reg || m_ready;
    assign s_ready   = advance;
    assign accept    = s_valid && advance;
    assign is_weight = (s_word.req_type == REQ_WEIGHT);

    // Effective counts: zero acts as one, large values clamp to MAX_INPUTS and MAX_OUTPUTS
    always_comb begin
        n_in = 17'(input_count_reg);
        if (n_in == 17'd0) begin
            n_in = 17'd1;
        end else if (n_in > MAX_IN_W) begin
            n_in = MAX_IN_W;
        end
        n_out = 17'(output_count_reg);
        if (n_out == 17'd0) begin
            n_out = 17'd1;
        end else if (n_out > MAX_OUT_W) begin
            n_out = MAX_OUT_W;
        end
    end

    assign col_plus  = 17'(col_reg) + 17'd1;
    assign row_plus  = 17'(row_reg) + 17'd1;
    assign row_end   = (col_plus >= n_in);
    assign layer_end = (row_plus >= n_out);

    // Advance the counters on every accepted weight word
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept && is_weight) begin
            if (row_end) begin
                col_next = '0;
                row_next = layer_end ? '0 : row_plus[RW-1:0];
            end else begin
                col_next = col_plus[CW-1:0];
            end
        end
    end

    // Loads beyond the store are dropped
    assign load_idx = 17'(s_word.element_index);
    assign load_we  = accept && !is_weight && (load_idx < MAX_IN_W);

    dlws_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_INPUTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (load_we),
        .wr_addr (load_idx[CW-1:0]),
        .wr_data (s_word.input_value),
        .rd_en   (advance),
        .rd_addr (col_reg),
        .rd_data (store_rd)
    );

    dlws_mac #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_mac (
        .mode     (input_mode_reg),
        .x        (signed'(store_rd)),
        .weight   (s1_wt_reg),
        .start    (s1_first_reg),
        .prior    (s1_prior_reg),
        .acc      (acc_reg),
        .acc_next (acc_next)
    );

    assign s1_emit = s1_valid_reg && s1_weight_reg && s1_end_reg;

    // Saturate the finished row to the output width
    always_comb begin
        acc_w = WW'(acc_next);
        if (acc_w > SUM_MAX) begin
            sum_sat = SUM_MAX[SUM_W-1:0];
        end else if (acc_w < SUM_MIN) begin
            sum_sat = SUM_MIN[SUM_W-1:0];
        end else begin
            sum_sat = acc_w[SUM_W-1:0];
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_count_reg  <= 11'd1;
            output_count_reg <= 13'd1;
            input_mode_reg   <= MODE_BIT;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_INPUT_COUNT:  input_count_reg  <= cfg_wdata[10:0];
                REG_OUTPUT_COUNT: output_count_reg <= cfg_wdata;
                REG_INPUT_MODE:   input_mode_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Counters, accumulator and valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            acc_reg      <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (advance) begin
                s1_valid_reg <= accept;
                if (s1_valid_reg && s1_weight_reg) begin
                    acc_reg <= acc_next;
                end
            end
            if (advance && s1_emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payload: capture the word and its place in the layer
    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_weight_reg   <= is_weight;
            s1_first_reg    <= (col_reg == '0);
            s1_end_reg      <= row_end;
            s1_row_reg      <= row_reg;
            s1_last_row_reg <= layer_end;
            s1_wt_reg       <= s_word.weight;
            s1_prior_reg    <= s_word.prior_result;
        end
        if (advance && s1_emit) begin
            m_word_reg.row_sum   <= sum_sat;
            m_word_reg.row_index <= ROW_W'(17'(s1_row_reg));
            m_word_reg.last_row  <= s1_last_row_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

// ===== design/dlws_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module dlws_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/dlws_mac.sv =====
// Multiply-accumulate step with saturation for the weighted sum block.
// Depends on dlws_pkg for mode codes and the byte offset.
module dlws_mac #(
    parameter int ACC_WIDTH = 48
) (
    input  logic [1:0]                    mode,
    input  logic signed [15:0]            x,
    input  logic signed [15:0]            weight,
    input  logic                          start,
    input  logic signed [47:0]            prior,
    input  logic signed [ACC_WIDTH-1:0]   acc,
    output logic signed [ACC_WIDTH-1:0]   acc_next
);
    import dlws_pkg::*;

    localparam int WW = 66;
    localparam logic signed [WW-1:0] ACC_MAX =
        signed'((WW'(1) << (ACC_WIDTH - 1)) - WW'(1));
    localparam logic signed [WW-1:0] ACC_MIN = -ACC_MAX - WW'(1);

    logic signed [31:0]          offset_w;
    logic signed [31:0]          bit_term;
    logic signed [31:0]          term;
    logic signed [WW-1:0]        prior_w;
    logic signed [ACC_WIDTH-1:0] prior_sat;
    logic signed [ACC_WIDTH-1:0] base;
    logic signed [WW-1:0]        sum_w;

    always_comb begin
        offset_w = signed'({24'b0, weight[7:0]}) - BYTE_OFFSET;
        bit_term = offset_w <<< Q16_SHIFT;
        case (mode)
            MODE_FIXED: term = 32'(x) * 32'(weight);
            MODE_BIT:   term = x[0] ? bit_term : 32'sd0;
            default:    term = x[0] ? bit_term : -bit_term;
        endcase
    end

    // Clamp the prior row value into the accumulator range
    always_comb begin
        prior_w = WW'(prior);
        if (prior_w > ACC_MAX) begin
            prior_sat = ACC_MAX[ACC_WIDTH-1:0];
        end else if (prior_w < ACC_MIN) begin
            prior_sat = ACC_MIN[ACC_WIDTH-1:0];
        end else begin
            prior_sat = prior_w[ACC_WIDTH-1:0];
        end
    end

    always_comb begin
        base  = start ? prior_sat : acc;
        sum_w = WW'(base) + WW'(term);
        if (sum_w > ACC_MAX) begin
            acc_next = ACC_MAX[ACC_WIDTH-1:0];
        end else if (sum_w < ACC_MIN) begin
            acc_next = ACC_MIN[ACC_WIDTH-1:0];
        end else begin
            acc_next = sum_w[ACC_WIDTH-1:0];
        end
    end

endmodule

// ===== design/dlws_checker.sv =====
// Port-level checks for the dense layer weighted sum block, bound to the top.
// Depends on dlws_pkg and dense_layer_weighted_sum.
module dlws_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input dlws_pkg::out_word_t m_word
);
    import dlws_pkg::*;

    // A held result word keeps its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Input backpressure only comes from a full, untaken result register
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // A new result must follow an earlier accepted input word
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready, 2))
        else $error("result appeared without a matching input word");

endmodule

bind dense_layer_weighted_sum dlws_checker u_dlws_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
